// ===== rtl/bti_pkg.sv =====
// shared types and constants of the breakpoint table interpolator
`default_nettype none

package bti_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int DIV_STEPS   = 33;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] REGION_INTERIOR = 2'd0;
  localparam logic [1:0] REGION_BELOW    = 2'd1;
  localparam logic [1:0] REGION_ABOVE    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_SCAN,
    ST_LEFT,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    RD_FIRST,
    RD_LAST,
    RD_ONE,
    RD_NEXT,
    RD_PREV
  } rd_sel_e;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_ZERO,
    RES_BELOW,
    RES_ABOVE,
    RES_INTERP
  } res_sel_e;

  typedef struct packed {
    logic     wr_en;
    logic     qry_load;
    rd_sel_e  rd_sel;
    logic     idx_init;
    logic     idx_inc;
    logic     load_right;
    logic     load_left;
    logic     mul_lo;
    logic     mul_hi;
    logic     div_init;
    logic     div_step;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic qx_le_rd;
    logic qx_ge_rd;
    logic idx_at_last;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/bti_ctrl.sv =====
// controller state machine of the breakpoint table interpolator
`default_nettype none

module bti_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire logic          cmd_i,
  input  wire bti_pkg::sts_t sts_i,
  output bti_pkg::cmd_t      cmd_o,
  output logic               busy
);

  bti_pkg::state_e                 state_q, state_d;
  logic [bti_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bti_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    case (state_q)
      bti_pkg::ST_IDLE: begin
        if (start && cmd_i == bti_pkg::CMD_QUERY) state_d = bti_pkg::ST_FIRST;
      end
      bti_pkg::ST_FIRST: begin
        state_d = sts_i.qx_le_rd ? bti_pkg::ST_IDLE : bti_pkg::ST_LAST;
      end
      bti_pkg::ST_LAST: begin
        state_d = sts_i.qx_ge_rd ? bti_pkg::ST_IDLE : bti_pkg::ST_SCAN;
      end
      bti_pkg::ST_SCAN: begin
        if (sts_i.idx_at_last || sts_i.qx_le_rd) state_d = bti_pkg::ST_LEFT;
      end
      bti_pkg::ST_LEFT:   state_d = bti_pkg::ST_MUL_LO;
      bti_pkg::ST_MUL_LO: state_d = bti_pkg::ST_MUL_HI;
      bti_pkg::ST_MUL_HI: state_d = bti_pkg::ST_SUM;
      bti_pkg::ST_SUM:    state_d = bti_pkg::ST_DIV;
      bti_pkg::ST_DIV: begin
        if (cnt_q == bti_pkg::DIV_CNT_W'(bti_pkg::DIV_STEPS - 1)) begin
          state_d = bti_pkg::ST_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      bti_pkg::ST_FIN:    state_d = bti_pkg::ST_IDLE;
      default:            state_d = bti_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel  = bti_pkg::RD_FIRST;
    cmd_o.res_sel = bti_pkg::RES_NONE;
    busy          = (state_q != bti_pkg::ST_IDLE);
    case (state_q)
      bti_pkg::ST_IDLE: begin
        if (start) begin
          if (cmd_i == bti_pkg::CMD_QUERY) begin
            cmd_o.qry_load = 1'b1;
            cmd_o.rd_sel   = bti_pkg::RD_FIRST;
          end else begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.res_sel = bti_pkg::RES_ZERO;
          end
        end
      end
      bti_pkg::ST_FIRST: begin
        if (sts_i.qx_le_rd) begin
          cmd_o.res_sel = bti_pkg::RES_BELOW;
        end else begin
          cmd_o.rd_sel = bti_pkg::RD_LAST;
        end
      end
      bti_pkg::ST_LAST: begin
        if (sts_i.qx_ge_rd) begin
          cmd_o.res_sel = bti_pkg::RES_ABOVE;
        end else begin
          cmd_o.idx_init = 1'b1;
          cmd_o.rd_sel   = bti_pkg::RD_ONE;
        end
      end
      bti_pkg::ST_SCAN: begin
        if (sts_i.idx_at_last || sts_i.qx_le_rd) begin
          cmd_o.load_right = 1'b1;
          cmd_o.rd_sel     = bti_pkg::RD_PREV;
        end else begin
          cmd_o.idx_inc = 1'b1;
          cmd_o.rd_sel  = bti_pkg::RD_NEXT;
        end
      end
      bti_pkg::ST_LEFT:   cmd_o.load_left = 1'b1;
      bti_pkg::ST_MUL_LO: cmd_o.mul_lo    = 1'b1;
      bti_pkg::ST_MUL_HI: cmd_o.mul_hi    = 1'b1;
      bti_pkg::ST_SUM:    cmd_o.div_init  = 1'b1;
      bti_pkg::ST_DIV:    cmd_o.div_step  = 1'b1;
      bti_pkg::ST_FIN:    cmd_o.res_sel   = bti_pkg::RES_INTERP;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/bti_dpath.sv =====
// datapath: breakpoint store, scan compare, split multiplier, serial divider
`default_nettype none

module bti_dpath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [4:0]         cfg_wdata_i,
  input  wire logic [3:0]         entry_index_i,
  input  wire logic signed [31:0] entry_x_i,
  input  wire logic signed [31:0] entry_y_i,
  input  wire logic signed [31:0] query_x_i,
  input  wire bti_pkg::cmd_t      cmd_i,
  output bti_pkg::sts_t           sts_o,
  output logic                    done_o,
  output logic signed [31:0]      y_out_o,
  output logic [1:0]              region_o
);

  localparam int IW = bti_pkg::IDX_W;

  logic [31:0]        mem_x [bti_pkg::TABLE_DEPTH];
  logic [31:0]        mem_y [bti_pkg::TABLE_DEPTH];

  logic [4:0]         used_q;
  logic               done_q;
  logic signed [31:0] rdx_q, rdy_q;
  logic signed [31:0] qx_q, rx_q, ry_q, ly_q;
  logic [IW-1:0]      last_q, idx_q;
  logic [IW-1:0]      raddr, waddr, last_d;
  logic               wr_ok;
  logic               neg_q;
  logic [32:0]        dyabs_q;
  logic [31:0]        dq_q, dx_q;
  logic [48:0]        plo_q, phi_q;
  logic [64:0]        prod;
  logic [31:0]        rem_q;
  logic [32:0]        sh_q;
  logic [32:0]        trial, trial_sub;
  logic [33:0]        interp;
  logic signed [31:0] y_q;
  logic [1:0]         region_q;

  // used count clamped to the table
  always_comb begin
    if (used_q == 5'd0) begin
      last_d = '0;
    end else if ({27'd0, used_q} > 32'(bti_pkg::TABLE_DEPTH)) begin
      last_d = IW'(bti_pkg::TABLE_DEPTH - 1);
    end else begin
      last_d = IW'(used_q - 5'd1);
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      bti_pkg::RD_FIRST: raddr = '0;
      bti_pkg::RD_LAST:  raddr = last_q;
      bti_pkg::RD_ONE:   raddr = IW'(1);
      bti_pkg::RD_NEXT:  raddr = idx_q + 1'b1;
      bti_pkg::RD_PREV:  raddr = idx_q - 1'b1;
      default:           raddr = '0;
    endcase
  end

  assign waddr = IW'(entry_index_i);
  assign wr_ok = ({28'd0, entry_index_i} < 32'(bti_pkg::TABLE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_ok) begin
      mem_x[waddr] <= entry_x_i;
      mem_y[waddr] <= entry_y_i;
    end
    rdx_q <= mem_x[raddr];
    rdy_q <= mem_y[raddr];
  end

  assign sts_o.qx_le_rd    = (qx_q <= rdx_q);
  assign sts_o.qx_ge_rd    = (qx_q >= rdx_q);
  assign sts_o.idx_at_last = (idx_q == last_q);

  // divider step, partial product sum and interpolated result
  assign trial     = {rem_q, sh_q[32]};
  assign trial_sub = trial - {1'b0, dx_q};
  assign prod      = {16'd0, plo_q} + {phi_q, 16'd0};
  assign interp    = neg_q ? ({{2{ly_q[31]}}, ly_q} - {1'b0, sh_q})
                           : ({{2{ly_q[31]}}, ly_q} + {1'b0, sh_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.qry_load) begin
      qx_q   <= query_x_i;
      last_q <= last_d;
    end
    if (cmd_i.idx_init) idx_q <= IW'(1);
    else if (cmd_i.idx_inc) idx_q <= idx_q + 1'b1;
    if (cmd_i.load_right) begin
      rx_q <= rdx_q;
      ry_q <= rdy_q;
    end
    if (cmd_i.load_left) begin
      ly_q    <= rdy_q;
      neg_q   <= (ry_q < rdy_q);
      dyabs_q <= (ry_q < rdy_q) ? ({rdy_q[31], rdy_q} - {ry_q[31], ry_q})
                                : ({ry_q[31], ry_q} - {rdy_q[31], rdy_q});
      dq_q    <= 32'(qx_q - rdx_q);
      dx_q    <= 32'(rx_q - rdx_q);
    end
    if (cmd_i.mul_lo) plo_q <= dyabs_q * dq_q[15:0];
    if (cmd_i.mul_hi) phi_q <= dyabs_q * dq_q[31:16];
    if (cmd_i.div_init) begin
      rem_q <= prod[64:33];
      sh_q  <= prod[32:0];
    end else if (cmd_i.div_step) begin
      if (trial >= {1'b0, dx_q}) begin
        rem_q <= trial_sub[31:0];
        sh_q  <= {sh_q[31:0], 1'b1};
      end else begin
        rem_q <= trial[31:0];
        sh_q  <= {sh_q[31:0], 1'b0};
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    case (cmd_i.res_sel)
      bti_pkg::RES_ZERO: begin
        y_q      <= '0;
        region_q <= bti_pkg::REGION_INTERIOR;
      end
      bti_pkg::RES_BELOW: begin
        y_q      <= rdy_q;
        region_q <= bti_pkg::REGION_BELOW;
      end
      bti_pkg::RES_ABOVE: begin
        y_q      <= rdy_q;
        region_q <= bti_pkg::REGION_ABOVE;
      end
      bti_pkg::RES_INTERP: begin
        y_q      <= interp[31:0];
        region_q <= bti_pkg::REGION_INTERIOR;
      end
      default: begin
        y_q      <= y_q;
        region_q <= region_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 5'd1;
      done_q <= 1'b0;
    end else begin
      if (cfg_we_i) used_q <= cfg_wdata_i;
      done_q <= (cmd_i.res_sel != bti_pkg::RES_NONE);
    end
  end

  assign done_o   = done_q;
  assign y_out_o  = y_q;
  assign region_o = region_q;

endmodule

`default_nettype wire

// ===== rtl/breakpoint_table_interpolator_top.sv =====
// top level of the breakpoint table interpolator
//
//  channel   | ports                                             | transfer when
//  ----------+---------------------------------------------------+------------------
//  command   | cmd_i entry_index_i entry_x_i entry_y_i query_x_i | start && !busy
//  result    | y_out_o region_o                                  | done_o
//  config    | cfg_wdata_i (entries_used)                        | cfg_we_i
//
//  a write item gives its result in the cycle after the transfer and leaves busy low
//  a query at or below the first x is clamped below, at or above the last x clamped above
//  an interior query scans from entry 1 up to at most depth-1 and then uses:
//  one table read per scan step, two 33x16 partial products, 33 divider steps
//  reset clears the controller, the result strobe and entries_used to 1
//  results cannot be stalled; done_o is high for exactly one cycle per item
`default_nettype none

module breakpoint_table_interpolator_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               cmd_i,
  input  wire logic [3:0]         entry_index_i,
  input  wire logic signed [31:0] entry_x_i,
  input  wire logic signed [31:0] entry_y_i,
  input  wire logic signed [31:0] query_x_i,
  input  wire logic               cfg_we_i,
  input  wire logic [4:0]         cfg_wdata_i,
  output logic                    done_o,
  output logic signed [31:0]      y_out_o,
  output logic [1:0]              region_o
);

  bti_pkg::cmd_t ctl_cmd;
  bti_pkg::sts_t dp_sts;

  bti_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .sts_i  (dp_sts),
    .cmd_o  (ctl_cmd),
    .busy   (busy)
  );

  bti_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .entry_index_i (entry_index_i),
    .entry_x_i     (entry_x_i),
    .entry_y_i     (entry_y_i),
    .query_x_i     (query_x_i),
    .cmd_i         (ctl_cmd),
    .sts_o         (dp_sts),
    .done_o        (done_o),
    .y_out_o       (y_out_o),
    .region_o      (region_o)
  );

endmodule

`default_nettype wire
